@@ rtl/core/eps_pkg.sv @@
// Shared types and codes for the election peer status table.
// Holds the peer record layout, register indexes, role codes and sequencer states.
// No dependencies.
package eps_pkg;

  // Action carried in the input tuser bit.
  localparam logic ACT_SAVE  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_QUORUM       = 3'd0;
  localparam logic [2:0] REG_LEADER_GROUP = 3'd1;
  localparam logic [2:0] REG_MY_GROUP     = 3'd2;
  localparam logic [2:0] REG_MY_PRIORITY  = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_US   = 3'd4;
  localparam logic [2:0] REG_SELF_NODE    = 3'd5;
  localparam logic [2:0] REG_SELF_PASSIVE = 3'd6;
  localparam logic [2:0] REG_SELF_WEIGHT  = 3'd7;

  // Peer role codes that matter to the scan.
  localparam logic [2:0] ROLE_UNKNOWN = 3'd0;
  localparam logic [2:0] ROLE_LOGGER  = 3'd3;
  localparam logic [2:0] ROLE_PASSIVE = 3'd4;

  // One stored peer record.
  typedef struct packed {
    logic [7:0]  weight;
    logic        future_hb;
    logic        in_majority;
    logic [7:0]  group;
    logic [2:0]  role;
    logic        member;
    logic [63:0] priority_req;
    logic [63:0] rx_time;
  } eps_rec_t;

  // Result of the shared subtractor.
  typedef struct packed {
    logic        borrow;
    logic [63:0] diff;
  } eps_sub_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DIFF,
    S_TMO,
    S_PRIO,
    S_DONE
  } eps_state_t;

endpackage

@@ rtl/core/eps_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module eps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/eps_sub_unit.sv @@
// Shared 64-bit subtractor used for the liveness and priority compares.
// Depends on eps_pkg for the result struct.
module eps_sub_unit (
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output eps_pkg::eps_sub_t res
);

  logic [64:0] wide;

  // The borrow out of a - b is set exactly when a < b.
  assign wide       = {1'b0, a} - {1'b0, b};
  assign res.borrow = wide[64];
  assign res.diff   = wide[63:0];

endmodule

@@ rtl/core/election_peer_status_table_core.sv @@
// Election peer status table: top level with the scan sequencer and configuration.
// Depends on eps_pkg, eps_ram and eps_sub_unit.
//
// A save beat (tuser 0) writes one peer record and gives no result.
// A query beat (tuser 1) scans every table entry in ascending order and gives one
// result beat. The result is written to the output register once the scan ends, later
// only while that register still holds an earlier result, and the next beat can be
// taken in the cycle in which the result becomes valid. The scan shares one 64-bit
// subtractor that each entry uses three times: now minus receive time, that
// difference against the timeout, and the priority compare. The block takes no new
// beat while a query scan runs, but a finished result may wait in the output
// register while the next beat is taken. The table reads as empty after reset
// through per-entry valid bits, so there is no clearing pass. The configuration
// port is always ready.
module election_peer_status_table_core #(
  parameter int NODES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata from bit 0: node_id[3], member[1], role[3], group[8], priority_req[64],
  // in_majority[1], future_hb[1], last_recv_time[64], weight[8], now_time[64], zero pad
  input  logic [223:0] in_tdata,
  // in_tuser: action[1]
  input  logic         in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata from bit 0: self_in_majority[1], best_found[1], best_node[3], zero pad
  output logic [7:0]   out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int AW = $clog2(NODES);
  localparam int IW = (AW > 3) ? AW : 3;
  localparam int VW = 8 + AW + 1;
  localparam int RW = $bits(eps_pkg::eps_rec_t);

  // Configuration registers.
  logic [9:0]  quorum_r;
  logic [7:0]  lead_grp_r;
  logic [7:0]  own_grp_r;
  logic [63:0] my_priority_r;
  logic [31:0] timeout_r;
  logic [2:0]  self_node_r;
  logic        self_passive_r;
  logic [7:0]  own_wt_r;

  // Sequencer state.
  eps_pkg::eps_state_t state_r, state_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [63:0]      now_r, now_nxt;
  logic [63:0]      diff_r, diff_nxt;
  logic             lt_r, lt_nxt;
  logic             live_r, live_nxt;
  logic [VW-1:0]    votes_r, votes_nxt;
  logic [7:0]       best_group_r, best_group_nxt;
  logic [63:0]      top_prio_r, top_prio_nxt;
  logic [AW-1:0]    best_r, best_nxt;
  logic             found_r, found_nxt;
  logic [NODES-1:0] valid_r, valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;

  // Input fields.
  logic [2:0]  in_node_id;
  logic [63:0] in_now;
  logic [IW-1:0] id_ext;
  logic        id_in_range;
  logic        in_fire;
  logic        save_fire;
  logic        query_fire;
  eps_pkg::eps_rec_t wr_rec;

  // Table access.
  logic [AW-1:0] raddr;
  logic [RW-1:0] rdata;
  eps_pkg::eps_rec_t rec;

  // Shared subtractor.
  logic [63:0]       sub_a, sub_b;
  eps_pkg::eps_sub_t sub_res;

  // Per-entry decisions.
  logic          is_self;
  logic          skip;
  logic          role_ok;
  logic          eligible;
  logic          gt;
  logic          upd;
  logic [VW-1:0] total;
  logic          major;
  logic [IW-1:0] best_ext;

  assign in_node_id = in_tdata[2:0];
  assign in_now     = in_tdata[216:153];

  assign wr_rec.rx_time      = in_tdata[144:81];
  assign wr_rec.priority_req = in_tdata[78:15];
  assign wr_rec.member       = in_tdata[3];
  assign wr_rec.role         = in_tdata[6:4];
  assign wr_rec.group        = in_tdata[14:7];
  assign wr_rec.in_majority  = in_tdata[79];
  assign wr_rec.future_hb    = in_tdata[80];
  assign wr_rec.weight       = in_tdata[152:145];

  assign id_ext      = IW'(in_node_id);
  assign id_in_range = ({1'b0, id_ext} < (IW + 1)'(NODES));

  assign in_tready  = (state_r == eps_pkg::S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign save_fire  = in_fire && (in_tuser == eps_pkg::ACT_SAVE);
  assign query_fire = in_fire && (in_tuser == eps_pkg::ACT_QUERY);

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // During the priority step the next entry is already addressed, so its data
  // is ready when that entry's difference step starts.
  assign raddr = (state_r == eps_pkg::S_PRIO) ? cnt_r + AW'(1) : cnt_r;

  eps_ram #(
    .WIDTH(RW),
    .DEPTH(NODES)
  ) u_table (
    .clk  (clk),
    .we   (save_fire && id_in_range),
    .waddr(id_ext[AW-1:0]),
    .wdata(wr_rec),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rec = eps_pkg::eps_rec_t'(rdata);

  always_comb begin
    unique case (state_r)
      eps_pkg::S_DIFF: begin
        sub_a = now_r;
        sub_b = rec.rx_time;
      end
      eps_pkg::S_TMO: begin
        sub_a = diff_r;
        sub_b = {32'd0, timeout_r};
      end
      eps_pkg::S_PRIO: begin
        sub_a = top_prio_r;
        sub_b = rec.priority_req;
      end
      default: begin
        sub_a = 64'd0;
        sub_b = 64'd0;
      end
    endcase
  end

  eps_sub_unit u_sub (
    .a  (sub_a),
    .b  (sub_b),
    .res(sub_res)
  );

  assign is_self  = (IW'(cnt_r) == IW'(self_node_r));
  assign skip     = is_self || !valid_r[cnt_r] || !rec.member;
  assign role_ok  = !(rec.role == eps_pkg::ROLE_UNKNOWN || rec.role == eps_pkg::ROLE_LOGGER ||
                      rec.role == eps_pkg::ROLE_PASSIVE);
  assign eligible = !skip && role_ok && live_r && !rec.future_hb && rec.in_majority;
  assign gt       = sub_res.borrow;
  // Off the leader group a leader-group peer or higher priority wins; in it, higher priority.
  assign upd      = eligible &&
                    ((best_group_r != lead_grp_r && (rec.group == lead_grp_r || gt)) ||
                     (best_group_r == rec.group && gt));

  assign total    = votes_r + VW'(own_wt_r);
  assign major    = !self_passive_r && (total >= VW'(quorum_r));
  assign best_ext = IW'(best_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    now_nxt        = now_r;
    diff_nxt       = diff_r;
    lt_nxt         = lt_r;
    live_nxt       = live_r;
    votes_nxt      = votes_r;
    best_group_nxt = best_group_r;
    top_prio_nxt   = top_prio_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      eps_pkg::S_IDLE: begin
        if (save_fire && id_in_range) begin
          valid_nxt[id_ext[AW-1:0]] = 1'b1;
        end
        if (query_fire) begin
          now_nxt        = in_now;
          cnt_nxt        = '0;
          votes_nxt      = '0;
          best_group_nxt = own_grp_r;
          top_prio_nxt   = my_priority_r;
          best_nxt       = '0;
          found_nxt      = 1'b0;
          state_nxt      = eps_pkg::S_FETCH;
        end
      end
      eps_pkg::S_FETCH: begin
        state_nxt = eps_pkg::S_DIFF;
      end
      eps_pkg::S_DIFF: begin
        lt_nxt    = sub_res.borrow;
        diff_nxt  = sub_res.diff;
        state_nxt = eps_pkg::S_TMO;
      end
      eps_pkg::S_TMO: begin
        live_nxt  = lt_r || sub_res.borrow;
        state_nxt = eps_pkg::S_PRIO;
      end
      eps_pkg::S_PRIO: begin
        if (!skip && live_r && rec.role != eps_pkg::ROLE_PASSIVE) begin
          votes_nxt = votes_r + VW'(rec.weight);
        end
        if (upd) begin
          best_group_nxt = rec.group;
          top_prio_nxt   = rec.priority_req;
          best_nxt       = cnt_r;
          found_nxt      = 1'b1;
        end
        if (cnt_r == AW'(NODES - 1)) begin
          state_nxt = eps_pkg::S_DONE;
        end else begin
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = eps_pkg::S_DIFF;
        end
      end
      eps_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'd0, (found_r ? best_ext[2:0] : 3'd0), found_r, major};
          state_nxt     = eps_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = eps_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= eps_pkg::S_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    diff_r       <= diff_nxt;
    lt_r         <= lt_nxt;
    live_r       <= live_nxt;
    votes_r      <= votes_nxt;
    best_group_r <= best_group_nxt;
    top_prio_r   <= top_prio_nxt;
    best_r       <= best_nxt;
    found_r      <= found_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quorum_r       <= 10'd0;
      lead_grp_r     <= 8'd0;
      own_grp_r      <= 8'd0;
      my_priority_r  <= 64'd0;
      timeout_r      <= 32'd0;
      self_node_r    <= 3'd0;
      self_passive_r <= 1'b0;
      own_wt_r       <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        eps_pkg::REG_QUORUM:       quorum_r       <= cfg_data[9:0];
        eps_pkg::REG_LEADER_GROUP: lead_grp_r     <= cfg_data[7:0];
        eps_pkg::REG_MY_GROUP:     own_grp_r      <= cfg_data[7:0];
        eps_pkg::REG_MY_PRIORITY:  my_priority_r  <= cfg_data;
        eps_pkg::REG_TIMEOUT_US:   timeout_r      <= cfg_data[31:0];
        eps_pkg::REG_SELF_NODE:    self_node_r    <= cfg_data[2:0];
        eps_pkg::REG_SELF_PASSIVE: self_passive_r <= cfg_data[0];
        eps_pkg::REG_SELF_WEIGHT:  own_wt_r       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // A result without a better peer never names one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[1] |-> out_data_r[4:2] == 3'd0)
    else $error("best_node set without best_found");

  // The scan index stays inside the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != eps_pkg::S_IDLE |-> cnt_r <= AW'(NODES - 1))
    else $error("scan index beyond table");

  // An accepted query starts the scan on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    query_fire |=> state_r == eps_pkg::S_FETCH)
    else $error("query beat did not start a scan");

  // Entry valid bits change only on an accepted save beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    !save_fire |=> $stable(valid_r))
    else $error("valid bits changed without a save");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for election_peer_status_table_core.
// Sends save and query beats, takes query verdicts from directed rows or its own
// copy of the peer table and settings, and compares the results. Depends on eps_pkg.
module tb_top;

  localparam int NODES        = 8;
  localparam int DRAIN_CYCLES = 3 * NODES + 14;
  localparam int WATCHDOG_MAX = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_PHASE   = 2;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_BEATS  = 95;
  localparam int MAX_REPORTS  = 10;

  // Role codes beyond the ones the package names.
  localparam logic [2:0] ROLE_LEADER    = 3'd1;
  localparam logic [2:0] ROLE_FOLLOWER  = 3'd2;
  localparam logic [2:0] ROLE_CANDIDATE = 3'd5;
  localparam logic [2:0] ROLE_SPARE_A   = 3'd6;
  localparam logic [2:0] ROLE_SPARE_B   = 3'd7;

  localparam logic [63:0] U64_MAX = '1;

  typedef struct packed {
    logic        act;
    logic [2:0]  node;
    logic        member;
    logic [2:0]  role;
    logic [7:0]  grp;
    logic [63:0] prio;
    logic        inmaj;
    logic        fut;
    logic [63:0] last;
    logic [7:0]  wt;
    logic [63:0] now;
  } beat_t;

  // Same layout as out_tdata[4:0].
  typedef struct packed {
    logic [2:0] node;
    logic       found;
    logic       maj;
  } verdict_t;

  typedef struct {
    logic [9:0]  quorum;
    logic [7:0]  lead_grp;
    logic [7:0]  own_grp;
    logic [63:0] my_prio;
    logic [31:0] timeout;
    logic [2:0]  self_node;
    logic        self_passive;
    logic [7:0]  own_wt;
  } elect_cfg_t;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [63:0] val;
    beat_t       beat;
    bit          typed;
    verdict_t    want;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic [223:0] in_tdata;
  logic         in_tuser;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  // Copy of the beat on the input bus, for the predictor.
  beat_t    cur_beat;
  bit       cur_typed;
  verdict_t cur_want;

  eps_pkg::eps_rec_t peer_tbl [NODES];
  elect_cfg_t ecfg;
  verdict_t   pending_verdicts [$];
  stim_row_t  dir_rows [$];

  int  errors    = 0;
  int  saves_n   = 0;
  int  queries_n = 0;
  int  checked_n = 0;
  int  maj_n     = 0;
  int  found_n   = 0;
  int  idle_cnt  = 0;
  int  phase_no  = -1;
  bit  quiet     = 0;
  bit  press_done = 0;

  election_peer_status_table_core #(
    .NODES(NODES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [223:0] pack_beat(beat_t b);
    return {7'd0, b.now, b.wt, b.last, b.fut, b.inmaj, b.prio, b.grp, b.role,
            b.member, b.node};
  endfunction

  // Majority and best-peer verdict of one query against the current table.
  function automatic verdict_t predict_election(logic [63:0] now);
    int unsigned votes;
    logic [7:0]  best_grp;
    logic [63:0] top_prio;
    logic        found;
    logic [2:0]  best;
    logic        live;
    eps_pkg::eps_rec_t r;
    verdict_t    v;
    votes     = 0;
    best_grp  = ecfg.own_grp;
    top_prio  = ecfg.my_prio;
    found     = 1'b0;
    best      = 3'd0;
    for (int i = 0; i < NODES; i++) begin
      r = peer_tbl[i];
      if (i == ecfg.self_node || !r.member) continue;
      live = (now < r.rx_time) ||
             (now - r.rx_time < {32'd0, ecfg.timeout});
      if (r.role != eps_pkg::ROLE_PASSIVE && live) votes += r.weight;
      if (r.role == eps_pkg::ROLE_UNKNOWN || r.role == eps_pkg::ROLE_LOGGER ||
          r.role == eps_pkg::ROLE_PASSIVE) continue;
      if (live && !r.future_hb && r.in_majority) begin
        // Until a leader-group peer is held, a leader-group peer or a higher
        // priority takes over; within the held group only priority counts.
        if (best_grp != ecfg.lead_grp &&
            (r.group == ecfg.lead_grp || r.priority_req > top_prio)) begin
          best_grp  = r.group;
          top_prio  = r.priority_req;
          best      = i[2:0];
          found     = 1'b1;
        end
        if (best_grp == r.group && r.priority_req > top_prio) begin
          top_prio  = r.priority_req;
          best      = i[2:0];
          found     = 1'b1;
        end
      end
    end
    v.maj   = !ecfg.self_passive && (votes + ecfg.own_wt >= ecfg.quorum);
    v.found = found;
    v.node  = found ? best : 3'd0;
    return v;
  endfunction

  task automatic add_reg(logic [2:0] idx, logic [63:0] val);
    stim_row_t r;
    r       = '{kind: ROW_REG, default: '0};
    r.kind  = ROW_REG;
    r.idx   = idx;
    r.val   = val;
    dir_rows.push_back(r);
  endtask

  task automatic add_save(logic [2:0] node, logic member, logic [2:0] role,
                          logic [7:0] grp, logic [63:0] prio, logic inmaj,
                          logic fut, logic [63:0] last, logic [7:0] wt);
    stim_row_t r;
    r             = '{kind: ROW_BEAT, default: '0};
    r.kind        = ROW_BEAT;
    r.beat        = '0;
    r.beat.act    = eps_pkg::ACT_SAVE;
    r.beat.node   = node;
    r.beat.member = member;
    r.beat.role   = role;
    r.beat.grp    = grp;
    r.beat.prio   = prio;
    r.beat.inmaj  = inmaj;
    r.beat.fut    = fut;
    r.beat.last   = last;
    r.beat.wt     = wt;
    dir_rows.push_back(r);
  endtask

  task automatic add_query(logic [63:0] now, bit typed, logic maj, logic found,
                           logic [2:0] node);
    stim_row_t r;
    r          = '{kind: ROW_BEAT, default: '0};
    r.kind     = ROW_BEAT;
    r.beat     = '0;
    r.beat.act = eps_pkg::ACT_QUERY;
    r.beat.now = now;
    r.typed    = typed;
    r.want     = '{node: node, found: found, maj: maj};
    dir_rows.push_back(r);
  endtask

  // Offers one beat and returns at the edge where it is taken, without touching
  // in_tvalid in that step so the next beat can follow back to back.
  task automatic send_beat(beat_t b, bit typed, verdict_t want);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_beat(b);
    in_tuser  <= b.act;
    cur_beat  <= b;
    cur_typed <= typed;
    cur_want  <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  // Register writes only go in once the block has gone quiet.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off while results are waiting.
  initial begin
    int hold;
    hold = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_no == HOLD_PHASE && out_tvalid && !press_done) begin
        press_done = 1'b1;
        hold = HOLD_CYCLES;
      end else if (hold == 0 && !quiet && $urandom_range(0, 99) < 20) begin
        hold = $urandom_range(1, 16);
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Tracks accepted beats on all three channels.
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    eps_pkg::eps_rec_t rec;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          eps_pkg::REG_QUORUM:       ecfg.quorum       = cfg_data[9:0];
          eps_pkg::REG_LEADER_GROUP: ecfg.lead_grp     = cfg_data[7:0];
          eps_pkg::REG_MY_GROUP:     ecfg.own_grp      = cfg_data[7:0];
          eps_pkg::REG_MY_PRIORITY:  ecfg.my_prio      = cfg_data;
          eps_pkg::REG_TIMEOUT_US:   ecfg.timeout      = cfg_data[31:0];
          eps_pkg::REG_SELF_NODE:    ecfg.self_node    = cfg_data[2:0];
          eps_pkg::REG_SELF_PASSIVE: ecfg.self_passive = cfg_data[0];
          eps_pkg::REG_SELF_WEIGHT:  ecfg.own_wt       = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (cur_beat.act == eps_pkg::ACT_SAVE) begin
          saves_n++;
          if (cur_beat.node < NODES) begin
            rec.weight       = cur_beat.wt;
            rec.future_hb    = cur_beat.fut;
            rec.in_majority  = cur_beat.inmaj;
            rec.group        = cur_beat.grp;
            rec.role         = cur_beat.role;
            rec.member       = cur_beat.member;
            rec.priority_req = cur_beat.prio;
            rec.rx_time      = cur_beat.last;
            peer_tbl[cur_beat.node] = rec;
          end
        end else begin
          queries_n++;
          want = predict_election(cur_beat.now);
          if (cur_typed) want = cur_want;
          pending_verdicts.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[4:0];
        if (pending_verdicts.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result beat %h arrived with no query outstanding",
                     $realtime, out_tdata);
        end else begin
          want = pending_verdicts.pop_front();
          checked_n++;
          if (got.maj) maj_n++;
          if (got.found) found_n++;
          if (got.maj !== want.maj || got.found !== want.found ||
              got.node !== want.node) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: verdict mismatch: maj %b/%b found %b/%b node %0d/%0d",
                       $realtime, want.maj, got.maj, want.found, got.found,
                       want.node, got.node);
          end
        end
      end
    end
  end

  // Ends the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_MAX) begin
      $display("%0t: watchdog: %0d cycles without a beat", $realtime, idle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    beat_t       b;
    logic [63:0] base;
    logic [9:0]  q;
    logic [7:0]  lg;
    logic [7:0]  mg;
    logic [63:0] mp;
    logic [31:0] tmo;
    logic [7:0]  sw;

    for (int i = 0; i < NODES; i++) peer_tbl[i] = '0;
    ecfg = '{quorum: '0, lead_grp: '0, own_grp: '0, my_prio: '0, timeout: '0,
             self_node: '0, self_passive: 1'b0, own_wt: 8'd1};

    // Empty table after reset: only the self weight counts.
    add_query(64'd0, 1'b1, 1'b1, 1'b0, 3'd0);
    add_reg(eps_pkg::REG_QUORUM, 64'd1023);
    add_reg(eps_pkg::REG_SELF_WEIGHT, 64'd255);
    add_query(64'd0, 1'b1, 1'b0, 1'b0, 3'd0);
    // A passive self never holds the majority, even with a zero quorum.
    add_reg(eps_pkg::REG_SELF_PASSIVE, 64'd1);
    add_reg(eps_pkg::REG_QUORUM, 64'd0);
    add_query(64'd0, 1'b1, 1'b0, 1'b0, 3'd0);
    add_reg(eps_pkg::REG_SELF_PASSIVE, 64'd0);
    add_reg(eps_pkg::REG_TIMEOUT_US, 64'hFFFF_FFFF);
    add_reg(eps_pkg::REG_LEADER_GROUP, 64'd5);
    add_reg(eps_pkg::REG_MY_GROUP, 64'd5);
    add_reg(eps_pkg::REG_MY_PRIORITY, 64'd100);
    add_reg(eps_pkg::REG_SELF_NODE, 64'd0);
    add_reg(eps_pkg::REG_QUORUM, 64'd10);
    add_reg(eps_pkg::REG_SELF_WEIGHT, 64'd1);
    // Self entry, a non-member, spare role codes, passive, logger, future
    // heartbeat and a receive time ahead of now.
    add_save(3'd0, 1'b1, ROLE_LEADER,    8'd5,   U64_MAX,  1'b1, 1'b0, 64'd1000, 8'd255);
    add_save(3'd1, 1'b1, ROLE_FOLLOWER,  8'd5,   64'd200,  1'b1, 1'b0, 64'd1000, 8'd4);
    add_save(3'd2, 1'b0, ROLE_FOLLOWER,  8'd5,   U64_MAX,  1'b1, 1'b0, 64'd1000, 8'd255);
    add_save(3'd3, 1'b1, ROLE_SPARE_A,   8'd7,   64'd300,  1'b1, 1'b0, 64'd1000, 8'd3);
    add_save(3'd4, 1'b1, eps_pkg::ROLE_PASSIVE, 8'd5, U64_MAX, 1'b1, 1'b0, 64'd1000,
             8'd200);
    add_save(3'd5, 1'b1, ROLE_SPARE_B,   8'd5,   U64_MAX,  1'b1, 1'b1, 64'd1000, 8'd255);
    add_save(3'd6, 1'b1, eps_pkg::ROLE_LOGGER, 8'd5, U64_MAX, 1'b1, 1'b0, 64'd1000,
             8'd8);
    add_save(3'd7, 1'b1, ROLE_CANDIDATE, 8'd255, 64'd0,    1'b0, 1'b0, U64_MAX,  8'd1);
    add_query(64'd1000, 1'b0, 1'b0, 1'b0, 3'd0);
    add_query(U64_MAX, 1'b0, 1'b0, 1'b0, 3'd0);
    // With a zero timeout only receive times ahead of now count as live.
    add_reg(eps_pkg::REG_TIMEOUT_US, 64'd0);
    add_query(64'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    add_reg(eps_pkg::REG_MY_GROUP, 64'd9);
    add_query(64'd500, 1'b0, 1'b0, 1'b0, 3'd0);
    add_save(3'd1, 1'b1, eps_pkg::ROLE_UNKNOWN, 8'd5, 64'd200, 1'b1, 1'b0, 64'd1000,
             8'd4);
    add_query(64'd500, 1'b0, 1'b0, 1'b0, 3'd0);
    add_reg(eps_pkg::REG_MY_PRIORITY, U64_MAX);
    add_query(64'd500, 1'b0, 1'b0, 1'b0, 3'd0);

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= eps_pkg::ACT_SAVE;
    cfg_valid  <= 1'b0;
    cfg_index  <= eps_pkg::REG_QUORUM;
    cfg_data   <= '0;
    cur_beat   <= '0;
    cur_typed  <= 1'b0;
    cur_want   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_REG)
        write_reg(dir_rows[k].idx, dir_rows[k].val);
      else
        send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_no = p;
      quiet    = (p == NUM_PHASES - 1);
      // Phases 0 and 1 pin quorum, groups, priority, timeout and weight to low and high extremes.
      case (p)
        0: begin
          q = '0; lg = '0; mg = '0; mp = '0; tmo = '0; sw = '0;
        end
        1: begin
          q = '1; lg = '1; mg = '1; mp = '1; tmo = '1; sw = '1;
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       q = '0;
            1:       q = '1;
            default: q = 10'($urandom_range(0, 40));
          endcase
          lg = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 3));
          mg = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 3));
          case ($urandom_range(0, 9))
            0:       mp = '0;
            1:       mp = '1;
            2:       mp = rand64();
            default: mp = 64'($urandom_range(0, 20));
          endcase
          case ($urandom_range(0, 9))
            0:       tmo = '0;
            1:       tmo = '1;
            2:       tmo = $urandom;
            default: tmo = 32'($urandom_range(0, 400));
          endcase
          case ($urandom_range(0, 9))
            0:       sw = '0;
            1:       sw = '1;
            default: sw = 8'($urandom_range(0, 10));
          endcase
        end
      endcase
      write_reg(eps_pkg::REG_QUORUM, 64'(q));
      write_reg(eps_pkg::REG_LEADER_GROUP, 64'(lg));
      write_reg(eps_pkg::REG_MY_GROUP, 64'(mg));
      write_reg(eps_pkg::REG_MY_PRIORITY, mp);
      write_reg(eps_pkg::REG_TIMEOUT_US, 64'(tmo));
      write_reg(eps_pkg::REG_SELF_NODE,
                (p == 1) ? 64'd7 : 64'($urandom_range(0, NODES - 1)));
      write_reg(eps_pkg::REG_SELF_PASSIVE, 64'($urandom_range(0, 4) == 0));
      write_reg(eps_pkg::REG_SELF_WEIGHT, 64'(sw));

      // Receive and query times cluster around a base so that liveness varies;
      // a base near the top of the range makes the times wrap.
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = U64_MAX - 64'd500;
        default: base = rand64();
      endcase

      for (int n = 0; n < PHASE_BEATS; n++) begin
        b = '0;
        if ($urandom_range(0, 9) == 0) begin
          b.act    = 1'($urandom_range(0, 1));
          b.node   = 3'($urandom_range(0, 7));
          b.member = 1'($urandom_range(0, 1));
          b.role   = 3'($urandom_range(0, 7));
          b.grp    = 8'($urandom_range(0, 255));
          b.prio   = rand64();
          b.inmaj  = 1'($urandom_range(0, 1));
          b.fut    = 1'($urandom_range(0, 1));
          b.last   = rand64();
          b.wt     = 8'($urandom_range(0, 255));
          b.now    = rand64();
        end else begin
          b.act    = ($urandom_range(0, 9) < 3) ? eps_pkg::ACT_QUERY : eps_pkg::ACT_SAVE;
          b.node   = 3'($urandom_range(0, NODES - 1));
          b.member = ($urandom_range(0, 99) < 85);
          b.role   = 3'($urandom_range(0, 7));
          case ($urandom_range(0, 3)) inside
            0, 1:    b.grp = lg;
            2:       b.grp = mg;
            default: b.grp = 8'($urandom_range(0, 255));
          endcase
          b.prio   = ($urandom_range(0, 4) == 0) ? rand64() : 64'($urandom_range(0, 20));
          b.inmaj  = ($urandom_range(0, 99) < 80);
          b.fut    = ($urandom_range(0, 99) < 20);
          b.last   = base + 64'($urandom_range(0, 600));
          b.wt     = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 15));
          b.now    = base + 64'($urandom_range(0, 900));
        end
        send_beat(b, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) errors++;

    $display("Run covered %0d save beats and %0d query beats over %0d settings phases.",
             saves_n, queries_n, NUM_PHASES + 1);
    $display("%0d verdicts checked: %0d with majority, %0d naming a better peer; %0d errors.",
             checked_n, maj_n, found_n, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
